// File: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the priority queue RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle
`define SPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

// Condition holds on every cycle out of reset
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("spq assertion failed");

`else

`define SPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/spq_pkg.sv
// -----------------------------------------------------------------------------
// spq_pkg
// Types and constants for the stable minimum priority queue.
// -----------------------------------------------------------------------------
package spq_pkg;

    // Beat field widths
    localparam int CMD_W     = 1;
    localparam int PAYLOAD_W = 32;
    localparam int PRIO_W    = 32;
    localparam int OCC_W     = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

    // Result status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle operation broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_spq_ctl;

endpackage

// File: rtl/spq_if.sv
// -----------------------------------------------------------------------------
// spq_if
// Command and response channel interfaces with valid/ready handshake.
// -----------------------------------------------------------------------------
interface spq_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::CMD_W-1:0]       command;
    logic [spq_pkg::PAYLOAD_W-1:0]   payload;
    logic [spq_pkg::PRIO_W-1:0]      priority_req;

    modport source (output valid, output command, output payload, output priority_req,
                    input ready);
    modport sink   (input valid, input command, input payload, input priority_req,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                            valid;
    logic                            ready;
    spq_pkg::t_status                status;
    logic [spq_pkg::PAYLOAD_W-1:0]   out_payload;
    logic [spq_pkg::OCC_W-1:0]       occupancy;
    logic                            is_empty;

    modport source (output valid, output status, output out_payload, output occupancy,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input out_payload, input occupancy,
                     input is_empty, output ready);
endinterface

// File: rtl/spq_cell.sv
// -----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift-register queue: holds an entry, decides
// locally whether to keep it, take the new entry or take a neighbor's.
// -----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIORITY_WIDTH = 32,
    parameter int PAYLOAD_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spq_pkg::t_spq_ctl         i_ctl,
    input  logic [PRIORITY_WIDTH-1:0] i_new_prio,
    input  logic [PAYLOAD_WIDTH-1:0]  i_new_payload,
    // left neighbor (closer to head)
    input  logic                      i_left_ins,
    input  logic                      i_left_valid,
    input  logic [PRIORITY_WIDTH-1:0] i_left_prio,
    input  logic [PAYLOAD_WIDTH-1:0]  i_left_payload,
    // right neighbor (closer to tail)
    input  logic                      i_right_valid,
    input  logic [PRIORITY_WIDTH-1:0] i_right_prio,
    input  logic [PAYLOAD_WIDTH-1:0]  i_right_payload,
    // own state
    output logic                      o_ins,
    output logic                      o_valid,
    output logic [PRIORITY_WIDTH-1:0] o_prio,
    output logic [PAYLOAD_WIDTH-1:0]  o_payload
);
    import spq_pkg::*;

    logic                      r_valid;
    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic [PAYLOAD_WIDTH-1:0]  r_payload;
    logic                      n_valid;
    logic [PRIORITY_WIDTH-1:0] n_prio;
    logic [PAYLOAD_WIDTH-1:0]  n_payload;

    // New entry lands here or further toward the head; ties stay behind
    assign o_ins = !r_valid || (i_new_prio < r_prio);

    // Select next contents: hold, insert, shift toward tail, or advance toward head
    always_comb begin
        n_valid   = r_valid;
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_ctl.enq && o_ins) begin
            if (i_left_ins) begin
                n_valid   = i_left_valid;
                n_prio    = i_left_prio;
                n_payload = i_left_payload;
            end else begin
                n_valid   = 1'b1;
                n_prio    = i_new_prio;
                n_payload = i_new_payload;
            end
        end else if (i_ctl.deq) begin
            n_valid   = i_right_valid;
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end
    end

    // Valid bit is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Entry data needs no reset
    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_valid   = r_valid;
    assign o_prio    = r_prio;
    assign o_payload = r_payload;

endmodule

// File: rtl/stable_min_priority_queue.sv
// Latency: a result beat is presented the cycle after its command beat is accepted.
// Throughput: one command per cycle while results are taken; every cell compares against the
// new priority and shifts in the same cycle, and one output register decouples the response side.
// Reset clears all cell valid bits and the occupancy count; no clearing pass is run.
// -----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded min-priority queue, FIFO among equal priorities, built as a sorted
// row of cells with the smallest priority at cell zero.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_min_priority_queue #(
    parameter int CAPACITY       = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_cmd_if.sink    i_cmd,
    spq_rsp_if.source  o_rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Cell row
    logic [CAPACITY-1:0]       w_valid;
    logic [CAPACITY-1:0]       w_ins;
    logic [PRIORITY_WIDTH-1:0] w_prio    [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0]  w_payload [CAPACITY];

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;

    logic                      r_out_valid;
    t_status                   r_status;
    logic [PAYLOAD_W-1:0]      r_out_payload;
    logic [OCC_W-1:0]          r_occ;
    logic                      r_empty;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_none;
    t_spq_ctl                  w_ctl;
    t_status                   w_status;
    logic [63:0]               w_pay_in_ext;
    logic [63:0]               w_prio_in_ext;
    logic [63:0]               w_pay_out_ext;
    logic [63:0]               w_occ_ext;
    logic [PAYLOAD_WIDTH-1:0]  w_new_payload;
    logic [PRIORITY_WIDTH-1:0] w_new_prio;
    logic                      w_reject;

    // Take a command beat whenever the output register is free or draining
    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_full = (r_count == CNT_W'(CAPACITY));
    assign w_none = (r_count == '0);

    // Fit the input fields to the stored widths
    assign w_pay_in_ext  = 64'(i_cmd.payload);
    assign w_prio_in_ext = 64'(i_cmd.priority_req);
    assign w_new_payload = w_pay_in_ext[PAYLOAD_WIDTH-1:0];
    assign w_new_prio    = w_prio_in_ext[PRIORITY_WIDTH-1:0];

    // Decode command into the cell operation, status and next count
    always_comb begin
        w_ctl    = '0;
        w_status = ST_OK;
        n_count  = r_count;
        unique case (i_cmd.command)
            CMD_ENQ: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.enq = w_accept;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            CMD_DEQ: begin
                if (w_none) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl.deq = w_accept;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Build the row of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                      w_l_ins;
            logic                      w_l_valid;
            logic [PRIORITY_WIDTH-1:0] w_l_prio;
            logic [PAYLOAD_WIDTH-1:0]  w_l_payload;
            logic                      w_r_valid;
            logic [PRIORITY_WIDTH-1:0] w_r_prio;
            logic [PAYLOAD_WIDTH-1:0]  w_r_payload;

            if (gi == 0) begin : g_head
                assign w_l_ins     = 1'b0;
                assign w_l_valid   = 1'b0;
                assign w_l_prio    = '0;
                assign w_l_payload = '0;
            end else begin : g_mid_l
                assign w_l_ins     = w_ins[gi-1];
                assign w_l_valid   = w_valid[gi-1];
                assign w_l_prio    = w_prio[gi-1];
                assign w_l_payload = w_payload[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_r_valid   = 1'b0;
                assign w_r_prio    = '0;
                assign w_r_payload = '0;
            end else begin : g_mid_r
                assign w_r_valid   = w_valid[gi+1];
                assign w_r_prio    = w_prio[gi+1];
                assign w_r_payload = w_payload[gi+1];
            end

            spq_cell #(
                .PRIORITY_WIDTH (PRIORITY_WIDTH),
                .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_ctl           (w_ctl),
                .i_new_prio      (w_new_prio),
                .i_new_payload   (w_new_payload),
                .i_left_ins      (w_l_ins),
                .i_left_valid    (w_l_valid),
                .i_left_prio     (w_l_prio),
                .i_left_payload  (w_l_payload),
                .i_right_valid   (w_r_valid),
                .i_right_prio    (w_r_prio),
                .i_right_payload (w_r_payload),
                .o_ins           (w_ins[gi]),
                .o_valid         (w_valid[gi]),
                .o_prio          (w_prio[gi]),
                .o_payload       (w_payload[gi])
            );
        end
    endgenerate

    // Fit head payload and count to the result fields
    assign w_pay_out_ext = 64'(w_payload[0]);
    assign w_occ_ext     = 64'(n_count);

    // Occupancy counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= w_status;
            r_out_payload <= w_ctl.deq ? w_pay_out_ext[PAYLOAD_W-1:0] : '0;
            r_occ         <= w_occ_ext[OCC_W-1:0];
            r_empty       <= (n_count == '0);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_payload = r_out_payload;
    assign o_rsp.occupancy   = r_occ;
    assign o_rsp.is_empty    = r_empty;

    // Valid cells must match the count
    `SPQ_ASSERT_ALWAYS(a_count_matches, i_clk, i_rst_n, $countones(w_valid) == int'(r_count))

    // A valid cell has a valid, no larger priority ahead of it
    generate
        for (gi = 1; gi < CAPACITY; gi++) begin : g_chk
            logic w_ordered;
            assign w_ordered = w_valid[gi-1] && (w_prio[gi-1] <= w_prio[gi]);
            `SPQ_ASSERT_IMPLIES(a_sorted, i_clk, i_rst_n, w_valid[gi], w_ordered)
        end
    endgenerate

    // A rejected command leaves the store untouched
    assign w_reject = w_accept && (w_status != ST_OK);
    `SPQ_ASSERT_NEXT(a_reject_hold, i_clk, i_rst_n, w_reject, r_count == $past(r_count))

    // Every accepted command produces a result beat
    `SPQ_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, w_accept, r_out_valid)

endmodule

// File: test/tb.sv
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the stable minimum priority queue. Commands go in
// through the command channel and every response beat is checked, field by
// field, against a sorted software copy of the store kept in step with the
// accepted commands. A short directed table comes first: empty and full
// status, extreme values and tie order. Random enqueue/dequeue bursts with
// random gaps, stalls and long response hold-offs follow.
// -----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_CMDS  = 1050;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_WAIT     = 17;

    typedef struct packed {
        t_status              status;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [OCC_W-1:0]     occupancy;
        logic                 is_empty;
    } t_rsp;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] data;
        logic [PRIO_W-1:0]    prio;
    } t_entry;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [PAYLOAD_W-1:0] data;
        logic [PRIO_W-1:0]    prio;
        logic [7:0]           reps;
        logic                 typed;
        t_rsp                 rsp;
    } t_vector;

    localparam t_rsp NO_RSP = '{ST_OK, 32'h0, 5'd0, 1'b0};

    // Directed commands; repeated rows add the repeat index to the payload
    // and take a little off the priority, so they mix ties and reordering.
    localparam int DIRECTED_ROWS = 12;
    localparam t_vector DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
        '{CMD_DEQ, 32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{ST_EMPTY, 32'h0, 5'd0, 1'b1}},
        '{CMD_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,  1'b1, '{ST_OK, 32'h0, 5'd1, 1'b0}},
        '{CMD_ENQ, 32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{ST_OK, 32'h0, 5'd2, 1'b0}},
        '{CMD_DEQ, 32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{ST_OK, 32'h0, 5'd1, 1'b0}},
        '{CMD_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,  1'b1,
          '{ST_OK, 32'hFFFF_FFFF, 5'd0, 1'b1}},
        '{CMD_ENQ, 32'hA5A5_0001, 32'd5,         8'd1,  1'b0, NO_RSP},
        '{CMD_ENQ, 32'h5A5A_0002, 32'd5,         8'd1,  1'b0, NO_RSP},
        '{CMD_ENQ, 32'hA5A5_0003, 32'd3,         8'd1,  1'b0, NO_RSP},
        '{CMD_ENQ, 32'h5A5A_0004, 32'd5,         8'd1,  1'b0, NO_RSP},
        '{CMD_ENQ, 32'h0000_0100, 32'h8000_0000, 8'd12, 1'b0, NO_RSP},
        '{CMD_ENQ, 32'hDEAD_BEEF, 32'h0000_0001, 8'd1,  1'b1, '{ST_FULL, 32'h0, 5'd16, 1'b0}},
        '{CMD_DEQ, 32'h0000_0000, 32'h0000_0000, 8'd5,  1'b0, NO_RSP}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spq_cmd_if cmd_bus ();
    spq_rsp_if rsp_bus ();

    stable_min_priority_queue #(
        .CAPACITY      (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_W),
        .PRIORITY_WIDTH(PRIO_W)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_bus),
        .o_rsp  (rsp_bus)
    );

    t_entry sorted_entries [$];
    t_rsp   pending_rsp [$];
    int     mismatch_count = 0;
    int     send_calm_left = 0;
    int     recv_calm_left = 0;
    int     rsp_beats      = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Apply one command to the sorted store and return the response it yields
    function automatic t_rsp apply_command(input logic [CMD_W-1:0] cmd,
                                           input logic [PAYLOAD_W-1:0] data,
                                           input logic [PRIO_W-1:0] prio);
        t_rsp   rsp;
        t_entry ent;
        int     pos;
        rsp.out_payload = '0;
        pos = 0;
        if (cmd == CMD_ENQ) begin
            if (sorted_entries.size() >= DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                // Go behind every entry of equal priority
                while (pos < sorted_entries.size() && sorted_entries[pos].prio <= prio)
                    pos++;
                ent.data = data;
                ent.prio = prio;
                sorted_entries.insert(pos, ent);
                rsp.status = ST_OK;
            end
        end else if (sorted_entries.size() == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            ent = sorted_entries.pop_front();
            rsp.out_payload = ent.data;
            rsp.status = ST_OK;
        end
        rsp.occupancy = OCC_W'(sorted_entries.size());
        rsp.is_empty  = (sorted_entries.size() == 0);
        return rsp;
    endfunction

    function automatic int draw_wait(ref int calm_left);
        int wait_cycles;
        if (calm_left > 0) begin
            calm_left--;
            wait_cycles = 0;
        end else begin
            wait_cycles = $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(10, 40);
        end
        return wait_cycles;
    endfunction

    // Offer one command beat, hold it until accepted, record its response
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [PAYLOAD_W-1:0] data,
                                input logic [PRIO_W-1:0] prio,
                                input logic typed, input t_rsp typed_rsp);
        int   gap;
        t_rsp predicted;
        gap = draw_wait(send_calm_left);
        if (gap > 0) begin
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.valid        = 1'b1;
        cmd_bus.command      = cmd;
        cmd_bus.payload      = data;
        cmd_bus.priority_req = prio;
        do @(posedge clk); while (!cmd_bus.ready);
        predicted = apply_command(cmd, data, prio);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_bus.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Command side: directed table, then random bursts
    initial begin
        t_vector                row;
        int unsigned            rep;
        int                     burst_left;
        int                     enq_pct;
        int                     sel;
        logic [CMD_W-1:0]       cmd;
        logic [PRIO_W-1:0]      prio;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_ENQ;
        cmd_bus.payload      = '0;
        cmd_bus.priority_req = '0;
        burst_left = 0;
        enq_pct    = 50;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED_TABLE[r];
            for (rep = 0; rep < row.reps; rep++)
                send_command(row.cmd, row.data + rep, row.prio - 32'(rep % 3),
                             row.typed, row.rsp);
        end
        wait_drained();

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            // Pick a burst flavor: filling, draining or balanced
            if (burst_left == 0) begin
                burst_left = $urandom_range(4, 40);
                case ($urandom_range(0, 3))
                    0:       enq_pct = 90;
                    1:       enq_pct = 10;
                    default: enq_pct = 50;
                endcase
            end
            burst_left--;
            cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            sel = $urandom_range(0, 9);
            if (sel < 5)
                prio = $urandom_range(0, 7);
            else if (sel < 8)
                prio = $urandom;
            else if (sel == 8)
                prio = '0;
            else
                prio = '1;
            send_command(cmd, $urandom, prio, 1'b0, NO_RSP);
            if (n == RANDOM_CMDS / 2)
                wait_drained();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("stable_min_priority_queue: match");
        else
            $display("stable_min_priority_queue: mismatch");
        $finish;
    end

    // Response side: random stalls, two long hold-offs, check every beat
    initial begin
        int   stall;
        t_rsp want;
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (rsp_beats == 40 || rsp_beats == 600)
                stall = HOLD_CYCLES;
            else
                stall = draw_wait(recv_calm_left);
            if (stall > 0) begin
                rsp_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_bus.ready = 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
            rsp_beats++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("response beat with no command pending",
                                32'(rsp_bus.status), 32'h0);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_bus.status !== want.status)
                    report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
                if (rsp_bus.out_payload !== want.out_payload)
                    report_mismatch("out_payload", rsp_bus.out_payload, want.out_payload);
                if (rsp_bus.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(rsp_bus.occupancy),
                                    32'(want.occupancy));
                if (rsp_bus.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(rsp_bus.is_empty), 32'(want.is_empty));
            end
            @(negedge clk);
        end
    end

    // Stop a hung run: count cycles with no beat on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("stable_min_priority_queue: mismatch");
        $finish;
    end

endmodule
